// ===== hw/rtl/gjmi_pkg.sv =====
// gjmi_pkg: shared types and constants of the gauss-jordan matrix inverse
// used by gjmi_div, gjmi_cell, gauss_jordan_matrix_inverse and gjmi_checker
`default_nettype none

package gjmi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_W = 32;
   localparam int ORDER_W = 4;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_IDENT,
      ST_PICK,
      ST_CHECK,
      ST_ELDIV,
      ST_EMIT,
      ST_NSTART,
      ST_NWAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_we;
      logic ident_we;
      logic div_start;
      logic norm_mode;
      logic emit_phase;
      logic emit_en;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gjmi_div.sv =====
// gjmi_div: restoring divider, one quotient bit per cycle, of |num| * 2^16 by |den|
// depends on gjmi_pkg
`default_nettype none

module gjmi_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          start,
   input  wire logic signed [VALUE_WIDTH-1:0]                 num,
   input  wire logic signed [VALUE_WIDTH-1:0]                 den,
   output logic                                               done,
   output logic [VALUE_WIDTH+gjmi_pkg::FRAC_BITS-1:0]         quot,
   output logic                                               neg
);
   import gjmi_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int DW = VW + FRAC_BITS;
   localparam int KW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff, dvd_in, q_ff, q_in;
   logic [VW-1:0] rem_ff, rem_in, ub_ff, ub_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in, neg_ff, neg_in;
   logic [VW:0] r2;
   logic [VW-1:0] num_mag, den_mag;

   always_comb begin
      num_mag = num[VW-1] ? (~num + 1'b1) : num;
      den_mag = den[VW-1] ? (~den + 1'b1) : den;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      ub_in   = ub_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      r2      = {rem_ff, dvd_ff[DW-1]};
      if (start) begin
         dvd_in = {num_mag, {FRAC_BITS{1'b0}}};
         q_in   = '0;
         rem_in = '0;
         ub_in  = den_mag;
         cnt_in = '0;
         run_in = 1'b1;
         neg_in = num[VW-1] ^ den[VW-1];
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         if (r2 >= {1'b0, ub_ff}) begin
            rem_in = VW'(r2 - {1'b0, ub_ff});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = r2[VW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == KW'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      ub_ff  <= ub_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign neg  = neg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gjmi_cell.sv =====
// gjmi_cell: one row of the augmented matrix, its divider and multiply-subtract
// depends on gjmi_pkg and gjmi_div; cells form a ring that carries the pivot row
`default_nettype none

module gjmi_cell #(
   parameter int MAX_ORDER = 8,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX = 0
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire gjmi_pkg::cell_ctl_type                     ctl,
   input  wire logic [$clog2(MAX_ORDER+1)-1:0]             n,
   input  wire logic [$clog2(MAX_ORDER)-1:0]               row_sel,
   input  wire logic [$clog2(2*MAX_ORDER)-1:0]             col_sel,
   input  wire logic signed [VALUE_WIDTH-1:0]              load_val,
   input  wire logic signed [VALUE_WIDTH-1:0]              piv_val,
   input  wire logic                                       tok_in_valid,
   input  wire logic                                       tok_in_neg,
   input  wire logic [VALUE_WIDTH-1:0]                     tok_in_mag,
   output logic                                            tok_out_valid,
   output logic                                            tok_out_neg,
   output logic [VALUE_WIDTH-1:0]                          tok_out_mag,
   output logic signed [VALUE_WIDTH-1:0]                   pick,
   output logic                                            diag_zero
);
   import gjmi_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int RW = $clog2(MAX_ORDER);
   localparam int NC = 2 * MAX_ORDER;
   localparam int DW = VW + FRAC_BITS;
   localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] ONE_V = (VW > FRAC_BITS + 1) ?
      ({{(VW-1){1'b0}}, 1'b1} << FRAC_BITS) : VMAX;

   function automatic logic [VW-1:0] mul_sat(input logic [2*VW-1:0] p, input logic ng);
      logic [VW-1:0] m;
      begin
         m = {1'b0, p[FRAC_BITS+VW-2:FRAC_BITS]};
         if (p[2*VW-1:FRAC_BITS+VW-1] != '0) mul_sat = ng ? VMIN : VMAX;
         else mul_sat = ng ? (~m + 1'b1) : m;
      end
   endfunction

   function automatic logic [VW-1:0] div_sat(input logic [DW-1:0] q, input logic ng);
      logic [VW-1:0] m;
      begin
         m = {1'b0, q[VW-2:0]};
         if (q[DW-1:VW-1] != '0) div_sat = ng ? VMIN : VMAX;
         else div_sat = ng ? (~m + 1'b1) : m;
      end
   endfunction

   function automatic logic [VW-1:0] sub_sat(input logic [VW-1:0] a, input logic [VW-1:0] b);
      logic [VW:0] d;
      begin
         d = {a[VW-1], a} - {b[VW-1], b};
         if (d[VW] != d[VW-1]) sub_sat = d[VW] ? VMIN : VMAX;
         else sub_sat = d[VW-1:0];
      end
   endfunction

   logic signed [VW-1:0] row_ff [NC];
   logic signed [VW-1:0] row_in [NC];
   logic [VW-1:0] t_mag_ff, t_mag_in;
   logic t_neg_ff, t_neg_in;
   logic tv_ff, tv_in, tn_ff, tn_in;
   logic [VW-1:0] tm_ff, tm_in;
   logic pv_ff, pv_in, ps_ff, ps_in;
   logic [2*VW-1:0] prod_ff, prod_in;
   logic mode_ff, mode_in, dz_ff, dz_in;
   logic is_piv, active, dstart, rot;
   logic [VW-1:0] head_new, head_mag, qv;
   logic signed [VW-1:0] den;
   logic ddone, dneg;
   logic [DW-1:0] dquot;

   assign is_piv = (row_sel == RW'(IDX));
   assign active = (IDX < int'(n)) && (ctl.norm_mode || !is_piv);
   assign dstart = ctl.div_start && active;
   assign den    = ctl.norm_mode ? row_ff[IDX] : piv_val;
   assign pick   = row_ff[col_sel];
   assign diag_zero = (row_ff[IDX] == '0);

   gjmi_div #(.VALUE_WIDTH(VW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart),
      .num   (pick),
      .den   (den),
      .done  (ddone),
      .quot  (dquot),
      .neg   (dneg)
   );

   always_comb begin
      row_in   = row_ff;
      t_mag_in = t_mag_ff;
      t_neg_in = t_neg_ff;
      mode_in  = mode_ff;
      dz_in    = dz_ff;
      qv       = div_sat(dquot, dneg);
      head_mag = row_ff[0][VW-1] ? (~row_ff[0] + 1'b1) : row_ff[0];
      tv_in    = 1'b0;
      tn_in    = tn_ff;
      tm_in    = tm_ff;
      pv_in    = 1'b0;
      ps_in    = tok_in_neg ^ t_neg_ff;
      prod_in  = (2*VW)'(tok_in_mag) * (2*VW)'(t_mag_ff);
      rot      = 1'b0;
      head_new = row_ff[0];
      if (ctl.emit_phase) begin
         if (is_piv) begin
            tv_in = ctl.emit_en;
            tn_in = row_ff[0][VW-1];
            tm_in = head_mag;
            rot   = ctl.emit_en;
         end else begin
            tv_in    = tok_in_valid;
            tn_in    = tok_in_neg;
            tm_in    = tok_in_mag;
            pv_in    = tok_in_valid;
            rot      = pv_ff;
            head_new = sub_sat(row_ff[0], mul_sat(prod_ff, ps_ff));
         end
      end
      if (rot) begin
         for (int k = 0; k < NC - 1; k++) row_in[k] = row_ff[k+1];
         row_in[NC-1] = head_new;
      end
      if (ctl.load_we && is_piv) row_in[col_sel] = load_val;
      if (ctl.ident_we) begin
         for (int k = 0; k < NC; k++) begin
            if (k >= int'(n) && k < 2 * int'(n))
               row_in[k] = ((k - int'(n)) == IDX) ? ONE_V : '0;
         end
      end
      if (dstart) begin
         mode_in = ctl.norm_mode;
         dz_in   = diag_zero;
      end
      if (ddone) begin
         if (mode_ff) begin
            row_in[col_sel] = dz_ff ? '0 : qv;
         end else begin
            t_neg_in = qv[VW-1];
            t_mag_in = qv[VW-1] ? (~qv + 1'b1) : qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         tv_ff <= tv_in;
         pv_ff <= pv_in;
      end
      row_ff   <= row_in;
      t_mag_ff <= t_mag_in;
      t_neg_ff <= t_neg_in;
      tn_ff    <= tn_in;
      tm_ff    <= tm_in;
      ps_ff    <= ps_in;
      prod_ff  <= prod_in;
      mode_ff  <= mode_in;
      dz_ff    <= dz_in;
   end

   assign tok_out_valid = tv_ff;
   assign tok_out_neg   = tn_ff;
   assign tok_out_mag   = tm_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gauss_jordan_matrix_inverse.sv =====
// gauss_jordan_matrix_inverse: top level, load control, pivot sequencer, output
// depends on gjmi_pkg and gjmi_cell (which uses gjmi_div)
//
// Usage: write the order n (1..MAX_ORDER, 0 acts as 1, larger acts as MAX_ORDER)
// on csr_matrix_order with csr_valid; csr_ready is always high. Then present the
// n*n matrix words row-major on req_elem_value, one per cycle, each taken on a
// clock edge with start high and busy low. After the last word busy goes high
// while a ring of MAX_ORDER row cells eliminates column by column; each pivot
// and the final row scaling use the bit-serial divider (VALUE_WIDTH + 16
// quotient bits) in every cell. The n*n inverse words then leave one per cycle
// on rsp_inv_value with rsp_strobe, rsp_last_out on the final word and
// rsp_singular on all words. Results cannot be held off: each word is shown for
// one cycle only.
// Reset (synchronous) clears the load position, the flag and the control state
// and sets the order to 3; matrix storage is not cleared.
`default_nettype none

module gauss_jordan_matrix_inverse #(
   parameter int MAX_ORDER = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [gjmi_pkg::ELEM_W-1:0]     req_elem_value,
   output logic                                        rsp_strobe,
   output logic signed [gjmi_pkg::ELEM_W-1:0]          rsp_inv_value,
   output logic                                        rsp_singular,
   output logic                                        rsp_last_out,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [gjmi_pkg::ORDER_W-1:0]           csr_matrix_order
);
   import gjmi_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int M = MAX_ORDER;
   localparam int RW = $clog2(M);
   localparam int CW = $clog2(2 * M);
   localparam int NW = $clog2(M + 1);
   localparam int LCW = $clog2(M * M + 1);
   localparam int DW = VW + FRAC_BITS;
   localparam int WCW = $clog2(DW + 3 * M + 4);
   localparam int DIV_WAIT = DW + 1;
   localparam int EMIT_LEN = 3 * M + 2;
   localparam logic signed [VW+31:0] LMAX = {{33{1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [VW+31:0] LMIN = {{33{1'b1}}, {(VW-1){1'b0}}};
   localparam logic signed [VW+31:0] OMAX = {{(VW+1){1'b0}}, {31{1'b1}}};
   localparam logic signed [VW+31:0] OMIN = {{(VW+1){1'b1}}, {31{1'b0}}};

   state_type state_ff, state_in;
   logic [ORDER_W-1:0] order_ff;
   logic [LCW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] lrow_ff, lrow_in, lcol_ff, lcol_in;
   logic [RW-1:0] idx_ff, idx_in, jdx_ff, jdx_in;
   logic [WCW-1:0] wait_ff, wait_in;
   logic signed [VW-1:0] pval_ff, pval_in;
   logic sing_ff, sing_in;
   logic strobe_ff, strobe_in, last_ff, last_in, rsing_ff, rsing_in;
   logic signed [ELEM_W-1:0] val_ff, val_in;

   logic [NW-1:0] n_eff;
   logic [RW-1:0] n_last, r_cur, c_cur;
   logic [LCW-1:0] total;
   logic restart, accept, any_dz;
   logic [RW-1:0] row_sel;
   logic [CW-1:0] col_sel;
   cell_ctl_type ctl;
   logic signed [VW+31:0] ext_l, ext_o;
   logic signed [VW-1:0] load_val;

   logic tv [M];
   logic tn [M];
   logic [VW-1:0] tm [M];
   logic signed [VW-1:0] pick_w [M];
   logic dz_w [M];

   always_comb begin
      if (order_ff == '0) n_eff = NW'(1);
      else if ({1'b0, order_ff} > 5'(M)) n_eff = NW'(M);
      else n_eff = NW'(order_ff);
   end

   assign n_last  = RW'(n_eff - 1'b1);
   assign total   = LCW'(n_eff) * LCW'(n_eff);
   assign restart = (cnt_ff >= total);
   assign r_cur   = restart ? '0 : lrow_ff;
   assign c_cur   = restart ? '0 : lcol_ff;
   assign accept  = start && !busy;
   assign ext_l   = {{VW{req_elem_value[ELEM_W-1]}}, req_elem_value};
   assign load_val = (ext_l > LMAX) ? LMAX[VW-1:0] :
                     (ext_l < LMIN) ? LMIN[VW-1:0] : ext_l[VW-1:0];
   assign ext_o   = {{32{pick_w[idx_ff][VW-1]}}, pick_w[idx_ff]};

   always_comb begin
      any_dz = 1'b0;
      for (int k = 0; k < M; k++) begin
         if (k < int'(n_eff)) any_dz = any_dz | dz_w[k];
      end
   end

   for (genvar g = 0; g < M; g++) begin : g_cell
      gjmi_cell #(
         .MAX_ORDER   (M),
         .VALUE_WIDTH (VW),
         .IDX         (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .n             (n_eff),
         .row_sel       (row_sel),
         .col_sel       (col_sel),
         .load_val      (load_val),
         .piv_val       (pval_ff),
         .tok_in_valid  (tv[(g + M - 1) % M]),
         .tok_in_neg    (tn[(g + M - 1) % M]),
         .tok_in_mag    (tm[(g + M - 1) % M]),
         .tok_out_valid (tv[g]),
         .tok_out_neg   (tn[g]),
         .tok_out_mag   (tm[g]),
         .pick          (pick_w[g]),
         .diag_zero     (dz_w[g])
      );
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lrow_in   = lrow_ff;
      lcol_in   = lcol_ff;
      idx_in    = idx_ff;
      jdx_in    = jdx_ff;
      wait_in   = wait_ff;
      pval_in   = pval_ff;
      sing_in   = sing_ff;
      strobe_in = 1'b0;
      last_in   = 1'b0;
      rsing_in  = sing_ff;
      val_in    = ext_o[ELEM_W-1:0];
      ctl       = '0;
      row_sel   = idx_ff;
      col_sel   = CW'(idx_ff);
      case (state_ff)
         ST_LOAD: begin
            row_sel = r_cur;
            col_sel = CW'(c_cur);
            if (accept) begin
               ctl.load_we = 1'b1;
               cnt_in = (restart ? '0 : cnt_ff) + 1'b1;
               if (c_cur == n_last) begin
                  lcol_in = '0;
                  lrow_in = r_cur + 1'b1;
               end else begin
                  lcol_in = c_cur + 1'b1;
                  lrow_in = r_cur;
               end
               if (((restart ? '0 : cnt_ff) + 1'b1) == total) state_in = ST_IDENT;
            end
         end
         ST_IDENT: begin
            ctl.ident_we = 1'b1;
            idx_in = '0;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            pval_in = pick_w[idx_ff];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            wait_in = '0;
            if (pval_ff == '0) begin
               sing_in = 1'b1;
               if (idx_ff == n_last) begin
                  idx_in = '0;
                  state_in = ST_NSTART;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_PICK;
               end
            end else begin
               ctl.div_start = 1'b1;
               state_in = ST_ELDIV;
            end
         end
         ST_ELDIV: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WCW'(DIV_WAIT)) begin
               wait_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ctl.emit_phase = 1'b1;
            ctl.emit_en = (wait_ff < WCW'(2 * M));
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WCW'(EMIT_LEN)) begin
               wait_in = '0;
               if (idx_ff == n_last) begin
                  idx_in = '0;
                  state_in = ST_NSTART;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_PICK;
               end
            end
         end
         ST_NSTART: begin
            col_sel = CW'(n_eff) + CW'(idx_ff);
            ctl.norm_mode = 1'b1;
            ctl.div_start = 1'b1;
            sing_in = sing_ff | any_dz;
            wait_in = '0;
            state_in = ST_NWAIT;
         end
         ST_NWAIT: begin
            col_sel = CW'(n_eff) + CW'(idx_ff);
            ctl.norm_mode = 1'b1;
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WCW'(DIV_WAIT)) begin
               wait_in = '0;
               if (idx_ff == n_last) begin
                  idx_in = '0;
                  jdx_in = '0;
                  state_in = ST_OUT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_NSTART;
               end
            end
         end
         ST_OUT: begin
            col_sel = CW'(n_eff) + CW'(jdx_ff);
            strobe_in = 1'b1;
            if (ext_o > OMAX) val_in = OMAX[ELEM_W-1:0];
            else if (ext_o < OMIN) val_in = OMIN[ELEM_W-1:0];
            if (jdx_ff == n_last) begin
               jdx_in = '0;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == n_last) begin
                  last_in  = 1'b1;
                  idx_in   = '0;
                  sing_in  = 1'b0;
                  cnt_in   = '0;
                  lrow_in  = '0;
                  lcol_in  = '0;
                  state_in = ST_LOAD;
               end
            end else begin
               jdx_in = jdx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         order_ff  <= ORDER_RESET;
         cnt_ff    <= '0;
         lrow_ff   <= '0;
         lcol_ff   <= '0;
         idx_ff    <= '0;
         jdx_ff    <= '0;
         wait_ff   <= '0;
         sing_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_valid && csr_ready) order_ff <= csr_matrix_order;
         cnt_ff    <= cnt_in;
         lrow_ff   <= lrow_in;
         lcol_ff   <= lcol_in;
         idx_ff    <= idx_in;
         jdx_ff    <= jdx_in;
         wait_ff   <= wait_in;
         sing_ff   <= sing_in;
         strobe_ff <= strobe_in;
      end
      pval_ff  <= pval_in;
      last_ff  <= last_in;
      rsing_ff <= rsing_in;
      val_ff   <= val_in;
   end

   assign busy          = (state_ff != ST_LOAD) || strobe_ff;
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = strobe_ff;
   assign rsp_inv_value = val_ff;
   assign rsp_singular  = rsing_ff;
   assign rsp_last_out  = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gjmi_checker.sv =====
// gjmi_checker: port-level checks of the result stream of the matrix inverse
// depends on gjmi_pkg; bound to gauss_jordan_matrix_inverse
`default_nettype none

module gjmi_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               busy,
   input wire logic                               rsp_strobe,
   input wire logic                               rsp_singular,
   input wire logic                               rsp_last_out,
   input wire logic signed [gjmi_pkg::ELEM_W-1:0] rsp_inv_value
);
   import gjmi_pkg::*;

   logic [ELEM_W-1:0] val_seen;
   assign val_seen = rsp_inv_value;

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word while not busy");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |-> rsp_strobe)
      else $error("last flag without result word");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_out |=> rsp_strobe)
      else $error("gap inside result burst");

   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_out |=> !rsp_strobe)
      else $error("result word after last");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) && !$isunknown(val_seen) |->
      rsp_singular == $past(rsp_singular))
      else $error("singular flag changed inside burst");

endmodule

bind gauss_jordan_matrix_inverse gjmi_checker u_gjmi_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_singular  (rsp_singular),
   .rsp_last_out  (rsp_last_out),
   .rsp_inv_value (rsp_inv_value)
);

`default_nettype wire
